/* hdl/huffman_code_builder_assert.svh */
// Assertion macros for the Huffman code builder.
`ifndef HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define HUF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define HUF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HUF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HUF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/huf_pkg.sv */
// Shared constants and types of the Huffman code builder.
package huf_pkg;

    localparam int MAX_LEAVES_DEF = 64;
    localparam int COUNT_W        = 40;
    localparam int SUM_W          = 47;
    localparam int LEAF_W         = 6;
    localparam int NUMLV_W        = 7;
    localparam int PATH_W         = 6;
    localparam int MIN_LEAVES     = 2;

    localparam logic [NUMLV_W-1:0] NUM_LEAVES_RST = 7'd64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_B_ISSUE,
        S_B_PICK,
        S_Q_WALK
    } t_state;

endpackage

/* hdl/huffman_code_builder.sv */
// Top level: two-queue Huffman tree build and leaf path query over two memories.
//
//  channel   direction  handshake                       payload
//  command   in         start & !busy                   i_func, i_leaf, i_count
//  result    out        o_result_valid (one cycle)      o_path_node, o_branch_bit, o_last
//  config    in         i_cfg_valid & o_cfg_ready       i_cfg_data
//
// A load writes one count. Loading leaf n-1 starts the build: each merge passes S_B_ISSUE
// and S_B_PICK twice (two count reads and two picks), its sum written back in the next
// S_B_ISSUE; a final S_B_ISSUE writes back the last sum, and busy stays high until then.
// A query reads the leaf's link entry, then gives one path step per link memory read.
// Reset is synchronous; no clearing pass, link valid bits are flip-flops.
// Results cannot be stalled; busy holds off the next command.
module huffman_code_builder #(
    parameter int MAX_LEAVES = huf_pkg::MAX_LEAVES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_func,
    input  logic [huf_pkg::LEAF_W-1:0]   i_leaf,
    input  logic [huf_pkg::COUNT_W-1:0]  i_count,
    output logic                         o_result_valid,
    output logic [huf_pkg::PATH_W-1:0]   o_path_node,
    output logic                         o_branch_bit,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [huf_pkg::NUMLV_W-1:0]  i_cfg_data
);

    import huf_pkg::*;

    `include "huffman_code_builder_assert.svh"

    localparam int NODES  = 2 * MAX_LEAVES - 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int LC_W   = $clog2(MAX_LEAVES + 1);
    localparam int D_W    = (NODE_W > PATH_W) ? NODE_W : PATH_W;

    t_state              r_state, n_state;
    logic [NUMLV_W-1:0]  r_num_leaves, n_num_leaves;
    logic [NODES-1:0]    r_valid, n_valid;
    logic [LC_W-1:0]     r_lc, n_lc;
    logic [NODE_W-1:0]   r_nc, n_nc;
    logic [NODE_W-1:0]   r_i, n_i;
    logic                r_second, n_second;
    logic                r_wr_pend, n_wr_pend;
    logic                r_fwd, n_fwd;
    logic [SUM_W-1:0]    r_cnt_a, n_cnt_a;
    logic [SUM_W-1:0]    r_sum, n_sum;

    logic [LC_W-1:0]     n_eff;
    logic [NODE_W-1:0]   last_idx;
    logic [NODE_W-1:0]   leaf_idx;
    logic                leaf_in_range, leaf_is_last;
    logic                start_fire, cfg_fire;

    logic                cnt_we;
    logic [NODE_W-1:0]   cnt_waddr, cnt_raddr_leaf;
    logic [SUM_W-1:0]    cnt_wdata, cnt_rd_leaf, cnt_rd_node, node_cnt, pick_cnt;
    logic                take_leaf;
    logic [NODE_W-1:0]   pick_idx;

    logic                lnk_we;
    logic [NODE_W-1:0]   lnk_raddr;
    logic [NODE_W:0]     lnk_wdata, lnk_rdata;
    logic [NODE_W-1:0]   lnk_rd_parent;
    logic [D_W-1:0]      path_diff;

    always_comb begin
        if (r_num_leaves < NUMLV_W'(MIN_LEAVES)) begin
            n_eff = LC_W'(MIN_LEAVES);
        end else if (r_num_leaves > NUMLV_W'(MAX_LEAVES)) begin
            n_eff = LC_W'(MAX_LEAVES);
        end else begin
            n_eff = LC_W'(r_num_leaves);
        end
    end

    assign last_idx      = NODE_W'({n_eff, 1'b0} - (LC_W + 1)'(2));
    assign leaf_idx      = NODE_W'(i_leaf);
    assign leaf_in_range = {1'b0, i_leaf} < NUMLV_W'(n_eff);
    assign leaf_is_last  = {1'b0, i_leaf} == (NUMLV_W'(n_eff) - NUMLV_W'(1));

    assign busy        = (r_state != S_IDLE);
    assign start_fire  = start && !busy;
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    assign cnt_raddr_leaf = (r_lc == '0) ? '0 : NODE_W'(r_lc - LC_W'(1));

    // node count just written back is forwarded to the next merge
    assign node_cnt  = r_fwd ? r_sum : cnt_rd_node;
    assign take_leaf = (r_lc != '0) && ((r_nc == r_i) || (cnt_rd_leaf < node_cnt));
    assign pick_idx  = take_leaf ? cnt_raddr_leaf : r_nc;
    assign pick_cnt  = take_leaf ? cnt_rd_leaf : node_cnt;
    assign lnk_wdata = {r_i, r_second};

    assign lnk_rd_parent  = lnk_rdata[NODE_W:1];
    assign path_diff      = D_W'(lnk_rd_parent) - D_W'(n_eff);
    assign o_result_valid = (r_state == S_Q_WALK);
    assign o_path_node    = path_diff[PATH_W-1:0];
    assign o_branch_bit   = lnk_rdata[0];
    assign o_last         = !r_valid[lnk_rd_parent];

    always_comb begin
        n_state      = r_state;
        n_num_leaves = r_num_leaves;
        n_valid      = r_valid;
        n_lc         = r_lc;
        n_nc         = r_nc;
        n_i          = r_i;
        n_second     = r_second;
        n_wr_pend    = r_wr_pend;
        n_fwd        = r_fwd;
        n_cnt_a      = r_cnt_a;
        n_sum        = r_sum;
        cnt_we       = 1'b0;
        cnt_waddr    = r_i;
        cnt_wdata    = r_sum;
        lnk_we       = 1'b0;
        lnk_raddr    = leaf_idx;

        if (cfg_fire) begin
            n_num_leaves = i_cfg_data;
            n_valid      = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (start_fire && leaf_in_range) begin
                    if (i_func == FUNC_LOAD) begin
                        cnt_we    = 1'b1;
                        cnt_waddr = leaf_idx;
                        cnt_wdata = SUM_W'(i_count);
                        if (leaf_is_last) begin
                            n_valid   = '0;
                            n_lc      = n_eff;
                            n_nc      = NODE_W'(n_eff);
                            n_i       = NODE_W'(n_eff);
                            n_second  = 1'b0;
                            n_wr_pend = 1'b0;
                            n_state   = S_B_ISSUE;
                        end
                    end else if (r_valid[leaf_idx]) begin
                        n_state = S_Q_WALK;
                    end
                end
            end
            S_B_ISSUE: begin
                n_fwd   = 1'b0;
                n_state = S_B_PICK;
                if (r_wr_pend) begin
                    cnt_we    = 1'b1;
                    n_wr_pend = 1'b0;
                    n_fwd     = (r_nc == r_i);
                    if (r_i == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + NODE_W'(1);
                    end
                end
            end
            S_B_PICK: begin
                lnk_we             = 1'b1;
                n_valid[pick_idx]  = 1'b1;
                if (take_leaf) begin
                    n_lc = r_lc - LC_W'(1);
                end else begin
                    n_nc = r_nc + NODE_W'(1);
                end
                if (!r_second) begin
                    n_cnt_a  = pick_cnt;
                    n_second = 1'b1;
                end else begin
                    n_sum     = r_cnt_a + pick_cnt;
                    n_second  = 1'b0;
                    n_wr_pend = 1'b1;
                end
                n_state = S_B_ISSUE;
            end
            S_Q_WALK: begin
                lnk_raddr = lnk_rd_parent;
                if (o_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_leaves <= NUM_LEAVES_RST;
            r_valid      <= '0;
            r_lc         <= '0;
            r_nc         <= '0;
            r_i          <= '0;
            r_second     <= 1'b0;
            r_wr_pend    <= 1'b0;
            r_fwd        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_num_leaves <= n_num_leaves;
            r_valid      <= n_valid;
            r_lc         <= n_lc;
            r_nc         <= n_nc;
            r_i          <= n_i;
            r_second     <= n_second;
            r_wr_pend    <= n_wr_pend;
            r_fwd        <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt_a <= n_cnt_a;
        r_sum   <= n_sum;
    end

    huf_count_ram #(
        .DEPTH  (NODES),
        .ADDR_W (NODE_W),
        .DATA_W (SUM_W)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_we      (cnt_we),
        .i_waddr   (cnt_waddr),
        .i_wdata   (cnt_wdata),
        .i_raddr_a (cnt_raddr_leaf),
        .i_raddr_b (r_nc),
        .o_rdata_a (cnt_rd_leaf),
        .o_rdata_b (cnt_rd_node)
    );

    huf_link_ram #(
        .DEPTH  (NODES),
        .ADDR_W (NODE_W),
        .DATA_W (NODE_W + 1)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (pick_idx),
        .i_wdata (lnk_wdata),
        .i_raddr (lnk_raddr),
        .o_rdata (lnk_rdata)
    );

    `HUF_ASSERT(a_last_ends_path, i_clk, i_rst_n, (o_result_valid && o_last) |=> !o_result_valid, "result after final path step")
    `HUF_ASSERT(a_node_cursor_bound, i_clk, i_rst_n, (r_state == S_B_PICK) |-> (r_nc <= r_i), "node cursor passed build index")
    `HUF_ASSERT(a_pick_has_candidate, i_clk, i_rst_n, (r_state == S_B_PICK) |-> ((r_lc != '0) || (r_nc != r_i)), "merge with no node to pick")
    `HUF_ASSERT(a_load_silent, i_clk, i_rst_n, (start && !busy && (i_func == FUNC_LOAD)) |=> !o_result_valid, "load transaction produced a result")
    `HUF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !busy, "busy after reset")

endmodule

/* hdl/huf_count_ram.sv */
// Node count memory: one write port, two registered read ports.
module huf_count_ram #(
    parameter int DEPTH  = 127,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 47
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

/* hdl/huf_link_ram.sv */
// Parent link and branch bit memory: one write port, one registered read port.
module huf_link_ram #(
    parameter int DEPTH  = 127,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the two-queue Huffman code builder: loads, builds and path walks.
module tb_top;
    import huf_pkg::*;

    localparam int TREE_NODES    = 2 * MAX_LEAVES_DEF - 1;
    localparam int SETTLE_CYCLES = 4 * MAX_LEAVES_DEF + 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 340;
    localparam int TAIL_START    = 280;
    localparam int REPORT_MAX    = 10;

    typedef enum {
        PAT_ZERO,
        PAT_SCRAMBLED,
        PAT_DOUBLING,
        PAT_FLAT,
        PAT_DESCENDING
    } t_pattern;

    typedef struct {
        logic               func;
        logic [LEAF_W-1:0]  leaf;
        logic [COUNT_W-1:0] count;
        bit                 idle_ok;
    } t_cmd;

    typedef struct {
        logic [PATH_W-1:0] node;
        logic              branch;
        logic              root;
    } t_step;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic               i_func         = FUNC_LOAD;
    logic [LEAF_W-1:0]  i_leaf         = '0;
    logic [COUNT_W-1:0] i_count        = '0;
    logic               o_result_valid;
    logic [PATH_W-1:0]  o_path_node;
    logic               o_branch_bit;
    logic               o_last;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [NUMLV_W-1:0] i_cfg_data     = NUM_LEAVES_RST;

    huffman_code_builder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_leaf         (i_leaf),
        .i_count        (i_count),
        .o_result_valid (o_result_valid),
        .o_path_node    (o_path_node),
        .o_branch_bit   (o_branch_bit),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // tree model
    logic [SUM_W-1:0]   weight_mem [TREE_NODES];
    logic [6:0]         parent_of  [TREE_NODES];
    bit                 has_parent [TREE_NODES];
    bit                 branch_of  [TREE_NODES];
    int unsigned        leaves_left;
    int unsigned        next_inner;
    logic [NUMLV_W-1:0] leaves_reg = NUM_LEAVES_RST;

    t_step       path_steps_due [$];
    t_cmd        cmd_q [$];
    int          gap_left     = 0;
    int          quiet_cycles = 0;
    int          mismatches   = 0;
    int          steps_seen   = 0;
    int          cmds_taken   = 0;
    int          builds       = 0;
    int          cfg_writes   = 0;
    int          random_items = 0;
    bit          in_random    = 1'b0;
    bit          idle_now     = 1'b0;
    int unsigned gen_leaves   = MAX_LEAVES_DEF;
    int unsigned leaf_plan [20] = '{127, 2, 7, 1, 13, 3, 5, 0, 9, 21,
                                    4, 6, 64, 11, 2, 17, 8, 3, 10, 100};

    function automatic int unsigned clamp_leaves(int unsigned v);
        if (v < MIN_LEAVES) return MIN_LEAVES;
        if (v > MAX_LEAVES_DEF) return MAX_LEAVES_DEF;
        return v;
    endfunction

    // leaf from the high end if no internal node is ready or it is strictly lighter than the next internal node
    function automatic int unsigned pick_lightest(int unsigned i);
        bit from_leaf;
        from_leaf = 1'b0;
        if (leaves_left > 0) begin
            if (next_inner >= i)
                from_leaf = 1'b1;
            else if (weight_mem[leaves_left - 1] < weight_mem[next_inner])
                from_leaf = 1'b1;
        end
        if (from_leaf) begin
            leaves_left--;
            return leaves_left;
        end
        next_inner++;
        return next_inner - 1;
    endfunction

    task automatic build_tree(int unsigned n);
        int unsigned a, b;
        for (int k = 0; k < TREE_NODES; k++) begin
            has_parent[k] = 1'b0;
            parent_of[k]  = '0;
            branch_of[k]  = 1'b0;
        end
        leaves_left = n;
        next_inner  = n;
        for (int unsigned i = n; i < 2 * n - 1 && i < TREE_NODES; i++) begin
            a = pick_lightest(i);
            b = pick_lightest(i);
            if (a >= TREE_NODES || b >= TREE_NODES) break;
            weight_mem[i] = weight_mem[a] + weight_mem[b];
            parent_of[a]  = 7'(i);
            parent_of[b]  = 7'(i);
            has_parent[a] = 1'b1;
            has_parent[b] = 1'b1;
            branch_of[b]  = 1'b1;
        end
        builds++;
    endtask

    task automatic track_command(t_cmd c);
        int unsigned n, j, p;
        t_step s;
        n = clamp_leaves(leaves_reg);
        if (c.leaf >= n) return;
        if (c.func == FUNC_LOAD) begin
            weight_mem[c.leaf] = SUM_W'(c.count);
            if (c.leaf == n - 1) build_tree(n);
            return;
        end
        j = c.leaf;
        for (int unsigned k = 0; k < n - 1 && k < 64; k++) begin
            if (j >= TREE_NODES || !has_parent[j]) break;
            p = parent_of[j];
            if (p >= TREE_NODES) break;
            s.node   = PATH_W'(p - n);
            s.branch = branch_of[j];
            s.root   = !has_parent[p];
            path_steps_due.insert(path_steps_due.size(), s);
            j = p;
        end
    endtask

    always @(posedge i_clk) begin : cmd_driver
        t_cmd nxt;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left  = 0;
        end else if (!(start && busy)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                nxt = cmd_q.pop_front();
                start   <= 1'b1;
                i_func  <= nxt.func;
                i_leaf  <= nxt.leaf;
                i_count <= nxt.count;
                if (nxt.idle_ok && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 14);
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_cmd  seen;
        t_step want;
        if (i_rst_n) begin
            // predict first so a same-edge result still finds its transaction
            if (start && !busy) begin
                seen.func    = i_func;
                seen.leaf    = i_leaf;
                seen.count   = i_count;
                seen.idle_ok = 1'b0;
                track_command(seen);
                cmds_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                leaves_reg = i_cfg_data;
                for (int k = 0; k < TREE_NODES; k++) has_parent[k] = 1'b0;
                cfg_writes++;
            end
            if (o_result_valid) begin
                steps_seen++;
                if (path_steps_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected path step: node=%0d branch=%0b last=%0b",
                                 o_path_node, o_branch_bit, o_last);
                end else begin
                    want = path_steps_due.pop_front();
                    if (o_path_node !== want.node || o_branch_bit !== want.branch ||
                        o_last !== want.root) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $write("path step %0d: expected node=%0d branch=%0b last=%0b,",
                                   steps_seen, want.node, want.branch, want.root);
                            $display(" got node=%0d branch=%0b last=%0b",
                                     o_path_node, o_branch_bit, o_last);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [COUNT_W-1:0] rand_count();
        return COUNT_W'({$urandom, $urandom});
    endfunction

    task automatic queue_cmd(logic func, int unsigned leaf, logic [COUNT_W-1:0] count);
        t_cmd c;
        c.func    = func;
        c.leaf    = LEAF_W'(leaf);
        c.count   = count;
        c.idle_ok = idle_now;
        cmd_q.insert(cmd_q.size(), c);
        if (in_random && !(func == FUNC_LOAD && leaf >= gen_leaves)) random_items++;
        if (random_items >= TAIL_START) idle_now = 1'b0;
    endtask

    // loads never hit the last leaf here, so no build starts before every count is written
    task automatic queue_noise();
        int unsigned lf;
        lf = $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 0) begin
            queue_cmd(FUNC_QUERY, lf, rand_count());
        end else begin
            if (lf == gen_leaves - 1) lf = 0;
            queue_cmd(FUNC_LOAD, lf, rand_count());
        end
    endtask

    task automatic queue_build(int unsigned n, t_pattern pat);
        logic [COUNT_W-1:0] cur, val;
        int unsigned sh;
        sh  = $urandom_range(4, 38);
        cur = rand_count();
        if ($urandom_range(0, 1) == 0) cur = cur >> $urandom_range(0, 36);
        for (int unsigned lf = 0; lf < n; lf++) begin
            case (pat)
                PAT_ZERO:      val = '0;
                PAT_SCRAMBLED: val = rand_count() >> $urandom_range(0, 20);
                PAT_DOUBLING:  val = COUNT_W'(1) << ((n - 1 - lf) > 39 ? 39 : (n - 1 - lf));
                PAT_FLAT:      val = cur;
                default: begin
                    val = cur;
                    cur = cur - ((rand_count() >> sh) > cur ? cur : (rand_count() >> sh));
                end
            endcase
            queue_cmd(FUNC_LOAD, lf, val);
            if (lf < n - 1 && $urandom_range(0, 9) == 0) queue_noise();
        end
    endtask

    task automatic settle();
        while (cmd_q.size() > 0 || start || path_steps_due.size() > 0) @(posedge i_clk);
        // a final load may still be building with nothing left to report
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic change_leaves(int unsigned v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= NUMLV_W'(v);
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        gen_leaves = clamp_leaves(v);
    endtask

    initial begin : stimulus
        t_pattern    pat;
        int unsigned r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: no tree yet, smallest trees, ties, register extremes
        idle_now = 1'b1;
        queue_cmd(FUNC_QUERY, 0, '0);
        queue_cmd(FUNC_QUERY, 63, '1);
        change_leaves(0);
        queue_cmd(FUNC_LOAD, 63, '1);
        queue_cmd(FUNC_LOAD, 0, '1);
        queue_cmd(FUNC_LOAD, 1, '0);
        queue_cmd(FUNC_QUERY, 0, '0);
        queue_cmd(FUNC_QUERY, 1, '1);
        queue_cmd(FUNC_QUERY, 2, '0);
        queue_cmd(FUNC_QUERY, 63, '0);
        queue_cmd(FUNC_LOAD, 1, '1);
        queue_cmd(FUNC_QUERY, 1, '0);
        change_leaves(3);
        queue_cmd(FUNC_QUERY, 0, '0);
        // leaf count equal to the first internal node: the node wins
        queue_cmd(FUNC_LOAD, 0, 40'd4);
        queue_cmd(FUNC_LOAD, 1, 40'd2);
        queue_cmd(FUNC_LOAD, 2, 40'd2);
        queue_cmd(FUNC_QUERY, 0, '0);
        queue_cmd(FUNC_QUERY, 2, '0);
        change_leaves(3);
        queue_cmd(FUNC_QUERY, 1, '0);
        change_leaves(1);
        queue_cmd(FUNC_LOAD, 0, 40'd7);
        queue_cmd(FUNC_LOAD, 1, 40'd9);
        queue_cmd(FUNC_QUERY, 0, '0);

        in_random = 1'b1;
        for (int ph = 0; random_items < RANDOM_ITEMS; ph++) begin
            change_leaves(leaf_plan[ph % 20]);
            idle_now = (random_items < TAIL_START) && ($urandom_range(0, 3) != 0);
            queue_cmd(FUNC_QUERY, $urandom_range(0, gen_leaves - 1), rand_count());
            repeat (gen_leaves > 32 ? 1 : $urandom_range(1, 3)) begin
                r = $urandom_range(0, 9);
                case (r)
                    0:       pat = PAT_ZERO;
                    1:       pat = PAT_SCRAMBLED;
                    2:       pat = PAT_DOUBLING;
                    3:       pat = PAT_FLAT;
                    default: pat = PAT_DESCENDING;
                endcase
                if (ph == 0) pat = PAT_ZERO;   // full-depth chain at the largest size
                queue_build(gen_leaves, pat);
                queue_cmd(FUNC_QUERY, gen_leaves - 1, rand_count());
                repeat ($urandom_range(3, 8)) begin
                    if ($urandom_range(0, 4) == 0)
                        queue_noise();
                    else
                        queue_cmd(FUNC_QUERY, $urandom_range(0, gen_leaves - 1), rand_count());
                end
            end
        end
        settle();

        $display("ran %0d commands with %0d tree builds and %0d path steps checked,",
                 cmds_taken, builds, steps_seen);
        $display("across %0d leaf-count writes; %0d mismatches", cfg_writes, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
